/* hw/rtl/cmeu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR emulation unit package
// Shared codes, table contents, command and result types of the unit.
// ----------------------------------------------------------------------------
package cmeu_pkg;

   // Operation codes of an input beat.
   localparam logic [2:0] OPC_CPUID  = 3'd0;
   localparam logic [2:0] OPC_TBL_WR = 3'd1;
   localparam logic [2:0] OPC_RDTSC  = 3'd2;
   localparam logic [2:0] OPC_RDMSR  = 3'd3;
   localparam logic [2:0] OPC_WRMSR  = 3'd4;

   // CPUID table geometry.
   localparam int TBL_DEPTH    = 20;
   localparam int SLOT_W       = $clog2(TBL_DEPTH);
   localparam int CPUID_WORDS  = 4;
   localparam int WIDX_W       = $clog2(CPUID_WORDS);
   localparam int CNT_W        = $clog2(CPUID_WORDS + 1);

   localparam logic [31:0] EXT_BIT = 32'h8000_0000;

   // Address of each table slot: bits 31..4 hold the leaf, bits 3..0 the word.
   localparam logic [31:0] TBL_ADDR [TBL_DEPTH] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0010, 32'h0000_0013,
      32'h8000_0000, 32'h8000_0012,
      32'h8000_0020, 32'h8000_0021, 32'h8000_0022, 32'h8000_0023,
      32'h8000_0030, 32'h8000_0031, 32'h8000_0032, 32'h8000_0033,
      32'h8000_0040, 32'h8000_0041, 32'h8000_0042, 32'h8000_0043
   };

   // Contents of each slot after reset.
   localparam logic [31:0] TBL_INIT [TBL_DEPTH] = '{
      32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0673, 32'h0182_a9ff,
      32'h8000_0004, 32'h0010_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
   };

   // Slots that hold the maximum basic and extended leaf.
   localparam logic [SLOT_W-1:0] SLOT_MAX_BASIC = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_MAX_EXT   = SLOT_W'(6);

   // MSR numbers.
   localparam logic [31:0] MSR_TSC         = 32'h0000_0010;
   localparam logic [31:0] MSR_SYS_BASE    = 32'h0000_0174;
   localparam int          SYSENTER_COUNT  = 3;
   localparam int          SYS_W           = $clog2(SYSENTER_COUNT);
   localparam logic [31:0] MSR_SYS_LAST    = MSR_SYS_BASE + 32'(SYSENTER_COUNT - 1);
   localparam logic [31:0] MSR_UCODE_REV   = 32'h0000_008b;
   localparam logic [31:0] MSR_MTRR_CAP    = 32'h0000_0250;
   localparam logic [31:0] MSR_MTRR_DEF    = 32'h0000_0258;
   localparam logic [31:0] MSR_MTRR_FIX16  = 32'h0000_0259;
   localparam logic [31:0] MSR_MTRR_FIX4_LO = 32'h0000_0268;
   localparam logic [31:0] MSR_MTRR_FIX4_HI = 32'h0000_026f;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Work classes that the front assigns to a beat.
   typedef enum logic [3:0] {
      KIND_CPUID,
      KIND_TBL_WR,
      KIND_TSC_RD,
      KIND_TSC_WR,
      KIND_SYS_RD,
      KIND_SYS_WR,
      KIND_ZERO_RD,
      KIND_FAULT,
      KIND_UNHANDLED
   } kind_type;

   // Sequencer states of the back.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CPUID,
      ST_TBL_WB
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } slot_hit_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      kind_type          kind;
      logic [31:0]       leaf;
      logic [SLOT_W-1:0] slot;
      logic [SYS_W-1:0]  sys_idx;
      logic [31:0]       keep_mask;
      logic [31:0]       set_bits;
      logic [63:0]       write_data;
      logic [63:0]       host_time;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
      logic [63:0] read_data;
      logic        general_protection;
      logic        handled;
   } rsp_type;

   // Finds the table slot of a CPUID word address.
   function automatic slot_hit_type slot_lookup(input logic [31:0] addr);
      slot_hit_type r;
      r = '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (TBL_ADDR[i] == addr) begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/cmeu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cmeu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR unit front end
// Accepts request beats and sorts each one into a work class for the back.
// ----------------------------------------------------------------------------
module cmeu_front
   import cmeu_pkg::*;
(
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_leaf,
   input  logic [1:0]  req_sub_register,
   input  logic [31:0] req_keep_mask,
   input  logic [31:0] req_set_bits,
   input  logic [31:0] req_msr_index,
   input  logic [63:0] req_write_data,
   input  logic [63:0] req_host_time,
   input  logic        queue_full,
   output logic        queue_push,
   output cmd_type     queue_cmd
);

   logic [31:0]      wr_addr;
   slot_hit_type     wr_slot;
   logic             msr_is_tsc;
   logic             msr_is_sys;
   logic             msr_is_zero;
   logic [31:0]      sys_offset;

   // Table write address keeps the extended bit of the leaf.
   assign wr_addr = {req_leaf[27:0], 4'h0} | {30'h0, req_sub_register} | (req_leaf & EXT_BIT);
   assign wr_slot = slot_lookup(wr_addr);

   // MSR decode.
   assign msr_is_tsc = (req_msr_index == MSR_TSC);
   assign msr_is_sys = (req_msr_index >= MSR_SYS_BASE) &&
                       (req_msr_index <= MSR_SYS_LAST);
   assign msr_is_zero = (req_msr_index == MSR_UCODE_REV) ||
                        (req_msr_index == MSR_MTRR_CAP) ||
                        (req_msr_index == MSR_MTRR_DEF) ||
                        (req_msr_index == MSR_MTRR_FIX16) ||
                        ((req_msr_index >= MSR_MTRR_FIX4_LO) &&
                         (req_msr_index <= MSR_MTRR_FIX4_HI));
   assign sys_offset = req_msr_index - MSR_SYS_BASE;

   // Classification of the beat.
   always_comb begin
      queue_cmd            = '0;
      queue_cmd.leaf       = req_leaf;
      queue_cmd.slot       = wr_slot.idx;
      queue_cmd.sys_idx    = sys_offset[SYS_W-1:0];
      queue_cmd.keep_mask  = req_keep_mask;
      queue_cmd.set_bits   = req_set_bits;
      queue_cmd.write_data = req_write_data;
      queue_cmd.host_time  = req_host_time;
      case (req_operation)
         OPC_CPUID: begin
            queue_cmd.kind = KIND_CPUID;
         end
         OPC_TBL_WR: begin
            queue_cmd.kind = wr_slot.hit ? KIND_TBL_WR : KIND_UNHANDLED;
         end
         OPC_RDTSC: begin
            queue_cmd.kind = KIND_TSC_RD;
         end
         OPC_RDMSR: begin
            if (msr_is_tsc) begin
               queue_cmd.kind = KIND_TSC_RD;
            end else if (msr_is_sys) begin
               queue_cmd.kind = KIND_SYS_RD;
            end else if (msr_is_zero) begin
               queue_cmd.kind = KIND_ZERO_RD;
            end else begin
               queue_cmd.kind = KIND_FAULT;
            end
         end
         OPC_WRMSR: begin
            if (msr_is_tsc) begin
               queue_cmd.kind = KIND_TSC_WR;
            end else if (msr_is_sys) begin
               queue_cmd.kind = KIND_SYS_WR;
            end else begin
               queue_cmd.kind = KIND_FAULT;
            end
         end
         default: begin
            queue_cmd.kind = KIND_UNHANDLED;
         end
      endcase
   end

   // Handshake toward the queue.
   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

endmodule

/* hw/rtl/cmeu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR unit command queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module cmeu_queue
   import cmeu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/cmeu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR unit back end
// Executes classified commands against the CPUID table and MSR state and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module cmeu_back
   import cmeu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  cmd_type queue_head,
   output logic    queue_pop,
   output logic    rsp_valid,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       base_ff, base_in;
   cmd_type           cur_ff, cur_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [31:0]       words_ff [CPUID_WORDS-1];
   logic [31:0]       words_in [CPUID_WORDS-1];
   logic [TBL_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]       max_basic_ff, max_basic_in;
   logic [31:0]       max_ext_ff, max_ext_in;
   logic [63:0]       tsc_offset_ff, tsc_offset_in;
   logic [63:0]       sys_ff [SYSENTER_COUNT];
   logic [63:0]       sys_in [SYSENTER_COUNT];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [31:0]       ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [31:0]       ram_rd_data;

   logic              out_free;
   logic [31:0]       head_base;
   logic              head_ext;
   slot_hit_type      word_look;
   logic [31:0]       read_word;
   logic [31:0]       old_word;
   logic [31:0]       merged_word;
   logic [CNT_W-1:0]  cnt_prev;

   // Table storage; slots not yet written read their reset contents.
   cmeu_ram #(
      .WIDTH (32),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_pop;

   // Base address of the requested CPUID leaf, clamped to the stored maxima.
   assign head_ext = queue_head.leaf[31] && (queue_head.leaf <= max_ext_ff);
   always_comb begin
      if (head_ext) begin
         head_base = {queue_head.leaf[27:0], 4'h0} | EXT_BIT;
      end else if (queue_head.leaf > max_basic_ff) begin
         head_base = {max_basic_ff[27:0], 4'h0};
      end else begin
         head_base = {queue_head.leaf[27:0], 4'h0};
      end
   end

   // Table word lookups.
   assign word_look   = slot_lookup(base_ff | {30'h0, cnt_ff[WIDX_W-1:0]});
   assign read_word   = !rd_hit_ff ? '0 :
                        (valid_ff[rd_slot_ff] ? ram_rd_data : TBL_INIT[rd_slot_ff]);
   assign old_word    = valid_ff[cur_ff.slot] ? ram_rd_data : TBL_INIT[cur_ff.slot];
   assign merged_word = (old_word & cur_ff.keep_mask) | cur_ff.set_bits;
   assign cnt_prev    = cnt_ff - CNT_W'(1);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      cur_in        = cur_ff;
      rd_hit_in     = rd_hit_ff;
      rd_slot_in    = rd_slot_ff;
      words_in      = words_ff;
      valid_in      = valid_ff;
      max_basic_in  = max_basic_ff;
      max_ext_in    = max_ext_ff;
      tsc_offset_in = tsc_offset_ff;
      sys_in        = sys_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_in        = rsp_ff;
      queue_pop     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff.slot;
      ram_wr_data   = merged_word;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = queue_head.slot;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && out_free) begin
               queue_pop = 1'b1;
               cur_in    = queue_head;
               rsp_in    = '0;
               case (queue_head.kind)
                  KIND_CPUID: begin
                     base_in  = head_base;
                     cnt_in   = '0;
                     state_in = ST_CPUID;
                  end
                  KIND_TBL_WR: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_TBL_WB;
                  end
                  KIND_TSC_RD: begin
                     rsp_in.read_data = tsc_offset_ff + queue_head.host_time;
                     rsp_in.handled   = 1'b1;
                     rsp_valid_in     = 1'b1;
                  end
                  KIND_TSC_WR: begin
                     tsc_offset_in  = queue_head.write_data - queue_head.host_time;
                     rsp_in.handled = 1'b1;
                     rsp_valid_in   = 1'b1;
                  end
                  KIND_SYS_RD: begin
                     rsp_in.read_data = sys_ff[queue_head.sys_idx];
                     rsp_in.handled   = 1'b1;
                     rsp_valid_in     = 1'b1;
                  end
                  KIND_SYS_WR: begin
                     sys_in[queue_head.sys_idx] = queue_head.write_data;
                     rsp_in.handled = 1'b1;
                     rsp_valid_in   = 1'b1;
                  end
                  KIND_ZERO_RD: begin
                     rsp_in.handled = 1'b1;
                     rsp_valid_in   = 1'b1;
                  end
                  KIND_FAULT: begin
                     rsp_in.general_protection = 1'b1;
                     rsp_in.handled            = 1'b1;
                     rsp_valid_in              = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // One table read per cycle; data of the previous read is captured.
         ST_CPUID: begin
            ram_rd_en   = (cnt_ff != CNT_W'(CPUID_WORDS));
            ram_rd_addr = word_look.idx;
            rd_hit_in   = word_look.hit;
            rd_slot_in  = word_look.idx;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0 && cnt_ff != CNT_W'(CPUID_WORDS)) begin
               words_in[cnt_prev[WIDX_W-1:0]] = read_word;
            end
            if (cnt_ff == CNT_W'(CPUID_WORDS)) begin
               rsp_in        = '0;
               rsp_in.word_a = words_ff[0];
               rsp_in.word_b = words_ff[1];
               rsp_in.word_c = words_ff[2];
               rsp_in.word_d = read_word;
               rsp_in.handled = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         // Merge and write back the table word read in the previous cycle.
         ST_TBL_WB: begin
            ram_wr_en = 1'b1;
            valid_in[cur_ff.slot] = 1'b1;
            if (cur_ff.slot == SLOT_MAX_BASIC) begin
               max_basic_in = merged_word;
            end
            if (cur_ff.slot == SLOT_MAX_EXT) begin
               max_ext_in = merged_word;
            end
            rsp_in         = '0;
            rsp_in.handled = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         max_basic_ff  <= TBL_INIT[SLOT_MAX_BASIC];
         max_ext_ff    <= TBL_INIT[SLOT_MAX_EXT];
         tsc_offset_ff <= '0;
         for (int i = 0; i < SYSENTER_COUNT; i++) begin
            sys_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         max_basic_ff  <= max_basic_in;
         max_ext_ff    <= max_ext_in;
         tsc_offset_ff <= tsc_offset_in;
         sys_ff        <= sys_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      cur_ff     <= cur_in;
      rd_hit_ff  <= rd_hit_in;
      rd_slot_ff <= rd_slot_in;
      words_ff   <= words_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* hw/rtl/cpuid_msr_emulation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR emulation unit
// Emulated CPUID table, TSC offset and SYSENTER MSRs of a virtual CPU.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as queue pushes: a beat is taken when req_push is high and
//   req_full is low. Each request gives exactly one result beat, shown on the
//   rsp_ ports while rsp_empty is low and taken when rsp_pop is high.
//   A front end classifies each beat into a two-entry command queue; the back
//   end executes one command at a time with a table RAM that has one read port.
//   Throughput: 1 beat per cycle for MSR and TSC work while the receiver
//   takes each result; a table write reads the word, then merges and writes
//   it back, and a cpuid fetches the four words in turn through the one RAM
//   read port; the back end takes no other command until it is done.
//   Reset restores the table contents, clears the TSC offset and SYSENTER
//   registers and empties the queue and the result register at once.
//   While the receiver stalls, the result register holds its beat and the
//   queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module cpuid_msr_emulation_unit
   import cmeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_leaf,
   input  logic [1:0]  req_sub_register,
   input  logic [31:0] req_keep_mask,
   input  logic [31:0] req_set_bits,
   input  logic [31:0] req_msr_index,
   input  logic [63:0] req_write_data,
   input  logic [63:0] req_host_time,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_word_a,
   output logic [31:0] rsp_word_b,
   output logic [31:0] rsp_word_c,
   output logic [31:0] rsp_word_d,
   output logic [63:0] rsp_read_data,
   output logic        rsp_general_protection,
   output logic        rsp_handled
);

   logic    queue_full;
   logic    queue_push;
   cmd_type queue_cmd;
   logic    queue_empty;
   logic    queue_pop;
   cmd_type queue_head;
   logic    rsp_valid;
   rsp_type rsp;

   // Front end: classification.
   cmeu_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_leaf         (req_leaf),
      .req_sub_register (req_sub_register),
      .req_keep_mask    (req_keep_mask),
      .req_set_bits     (req_set_bits),
      .req_msr_index    (req_msr_index),
      .req_write_data   (req_write_data),
      .req_host_time    (req_host_time),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_cmd        (queue_cmd)
   );

   // Command queue.
   cmeu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (queue_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   // Back end: execution and result register.
   cmeu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_pop     (rsp_pop),
      .rsp         (rsp)
   );

   // Result beat.
   assign rsp_empty              = !rsp_valid;
   assign rsp_word_a             = rsp.word_a;
   assign rsp_word_b             = rsp.word_b;
   assign rsp_word_c             = rsp.word_c;
   assign rsp_word_d             = rsp.word_d;
   assign rsp_read_data          = rsp.read_data;
   assign rsp_general_protection = rsp.general_protection;
   assign rsp_handled            = rsp.handled;

endmodule

/* tb/sv/cpuid_msr_emulation_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID and MSR emulation unit testbench
// Pushes directed and random CPUID, table write, TSC and MSR requests through
// the unit. Each accepted request is run through an in-bench model of the
// CPUID table, TSC offset and SYSENTER registers. Each popped result is
// checked field by field against the oldest prediction. Both sides idle in
// random bursts, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module cpuid_msr_emulation_unit_tb
   import cmeu_pkg::*;
();

   // Codes and constants of the emulated CPU.
   localparam logic [2:0]  OPC_FIRST_UNUSED = OPC_WRMSR + 3'd1;
   localparam logic [2:0]  OPC_LAST_UNUSED  = 3'd7;
   localparam int          CPUID_SLOTS      = 20;
   localparam logic [31:0] EXT_FLAG         = 32'h8000_0000;
   localparam logic [31:0] MAX_BASIC_ADDR   = 32'h0000_0000;
   localparam logic [31:0] MAX_EXT_ADDR     = 32'h8000_0000;
   localparam logic [31:0] MSR_NUM_TSC      = 32'h0000_0010;
   localparam logic [31:0] MSR_NUM_SYS_CS   = 32'h0000_0174;
   localparam logic [31:0] MSR_NUM_SYS_EIP  = 32'h0000_0176;
   localparam logic [31:0] MSR_NUM_UCODE    = 32'h0000_008b;
   localparam logic [31:0] MSR_NUM_MTRR_CAP = 32'h0000_0250;
   localparam logic [31:0] MSR_NUM_MTRR_DEF = 32'h0000_0258;
   localparam logic [31:0] MSR_NUM_FIX16    = 32'h0000_0259;
   localparam logic [31:0] MSR_NUM_FIX4_LO  = 32'h0000_0268;
   localparam logic [31:0] MSR_NUM_FIX4_HI  = 32'h0000_026f;

   localparam logic [31:0] CPUID_ADDR [CPUID_SLOTS] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0010, 32'h0000_0013,
      32'h8000_0000, 32'h8000_0012,
      32'h8000_0020, 32'h8000_0021, 32'h8000_0022, 32'h8000_0023,
      32'h8000_0030, 32'h8000_0031, 32'h8000_0032, 32'h8000_0033,
      32'h8000_0040, 32'h8000_0041, 32'h8000_0042, 32'h8000_0043
   };
   localparam logic [31:0] CPUID_INIT [CPUID_SLOTS] = '{
      32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0673, 32'h0182_a9ff,
      32'h8000_0004, 32'h0010_0000,
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 32'h0
   };

   // Leaves and MSR numbers that matter to the unit.
   localparam logic [31:0] LEAF_PICKS [14] = '{
      32'h0, 32'h1, 32'h2, 32'h3, 32'h4,
      32'h8000_0000, 32'h8000_0001, 32'h8000_0002, 32'h8000_0003,
      32'h8000_0004, 32'h8000_0005, 32'h0800_0002, 32'h0800_0004, 32'h1000_0001
   };
   localparam logic [31:0] MSR_PICKS [16] = '{
      32'h10, 32'h174, 32'h175, 32'h176, 32'h173, 32'h177, 32'h8b, 32'h250,
      32'h258, 32'h259, 32'h268, 32'h26b, 32'h26f, 32'h267, 32'h270, 32'h0
   };

   // Run shape.
   localparam int TOTAL_ITEMS     = 1650;
   localparam int QUIET_ITEMS     = 150;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PRINT_LIMIT     = 50;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] leaf;
      logic [1:0]  sub_register;
      logic [31:0] keep_mask;
      logic [31:0] set_bits;
      logic [31:0] msr_index;
      logic [63:0] write_data;
      logic [63:0] host_time;
   } cpu_req_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        rsp_pop   = 1'b0;
   cpu_req_type cur_req   = '0;
   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_word_a;
   logic [31:0] rsp_word_b;
   logic [31:0] rsp_word_c;
   logic [31:0] rsp_word_d;
   logic [63:0] rsp_read_data;
   logic        rsp_general_protection;
   logic        rsp_handled;

   // Model state of the emulated CPU.
   logic [31:0] table_words [CPUID_SLOTS];
   logic [63:0] tsc_off;
   logic [63:0] sysenter_q [3];

   cpu_req_type pending_req [$];
   rsp_type     expected_rsp [$];
   rsp_type     got_rsp;
   rsp_type     want_rsp;

   int  error_count   = 0;
   int  req_count     = 0;
   int  rsp_count     = 0;
   int  total_items   = TOTAL_ITEMS;
   int  send_gap      = 0;
   int  pop_gap       = 0;
   int  hold_left     = 0;
   int  idle_cycles   = 0;
   logic req_taken     = 1'b0;
   logic quiet_phase   = 1'b0;
   logic pressure_done = 1'b0;

   cpuid_msr_emulation_unit i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_operation          (cur_req.operation),
      .req_leaf               (cur_req.leaf),
      .req_sub_register       (cur_req.sub_register),
      .req_keep_mask          (cur_req.keep_mask),
      .req_set_bits           (cur_req.set_bits),
      .req_msr_index          (cur_req.msr_index),
      .req_write_data         (cur_req.write_data),
      .req_host_time          (cur_req.host_time),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_word_a             (rsp_word_a),
      .rsp_word_b             (rsp_word_b),
      .rsp_word_c             (rsp_word_c),
      .rsp_word_d             (rsp_word_d),
      .rsp_read_data          (rsp_read_data),
      .rsp_general_protection (rsp_general_protection),
      .rsp_handled            (rsp_handled)
   );

   // Free-running clock.
   always #1 clock = ~clock;

   // Slot of a CPUID word address, or -1 when the table has no such word.
   function automatic int slot_of(input logic [31:0] addr);
      int slot;
      slot = -1;
      for (int i = 0; i < CPUID_SLOTS; i++) begin
         if (CPUID_ADDR[i] == addr) begin
            slot = i;
         end
      end
      return slot;
   endfunction

   function automatic logic [31:0] table_read(input logic [31:0] addr);
      int slot;
      slot = slot_of(addr);
      return (slot < 0) ? 32'h0 : table_words[slot[4:0]];
   endfunction

   // MTRR and microcode MSRs read as zero.
   function automatic logic msr_reads_zero(input logic [31:0] n);
      return n == MSR_NUM_UCODE || n == MSR_NUM_MTRR_CAP || n == MSR_NUM_MTRR_DEF ||
             n == MSR_NUM_FIX16 || (n >= MSR_NUM_FIX4_LO && n <= MSR_NUM_FIX4_HI);
   endfunction

   // Executes one request on the model state and returns its result beat.
   function automatic rsp_type emulate_op(input cpu_req_type it);
      rsp_type     r;
      logic [31:0] base;
      logic [31:0] addr;
      logic [31:0] max_basic;
      logic [31:0] sys_off;
      int          slot;
      r = '0;
      r.handled = 1'b1;
      sys_off = it.msr_index - MSR_NUM_SYS_CS;
      case (it.operation)
         OPC_CPUID: begin
            max_basic = table_read(MAX_BASIC_ADDR);
            if (it.leaf[31] && it.leaf <= table_read(MAX_EXT_ADDR)) begin
               base = {it.leaf[27:0], 4'h0} | EXT_FLAG;
            end else if (it.leaf > max_basic) begin
               base = {max_basic[27:0], 4'h0};
            end else begin
               base = {it.leaf[27:0], 4'h0};
            end
            r.word_a = table_read(base | 32'd0);
            r.word_b = table_read(base | 32'd1);
            r.word_c = table_read(base | 32'd2);
            r.word_d = table_read(base | 32'd3);
         end
         OPC_TBL_WR: begin
            addr = {it.leaf[27:0], 4'h0} | {30'd0, it.sub_register} | (it.leaf & EXT_FLAG);
            slot = slot_of(addr);
            if (slot < 0) begin
               r.handled = 1'b0;
            end else begin
               table_words[slot[4:0]] = (table_words[slot[4:0]] & it.keep_mask) |
                                        it.set_bits;
            end
         end
         OPC_RDTSC: begin
            r.read_data = tsc_off + it.host_time;
         end
         OPC_RDMSR: begin
            if (it.msr_index == MSR_NUM_TSC) begin
               r.read_data = tsc_off + it.host_time;
            end else if (it.msr_index >= MSR_NUM_SYS_CS && it.msr_index <= MSR_NUM_SYS_EIP) begin
               r.read_data = sysenter_q[sys_off[1:0]];
            end else if (!msr_reads_zero(it.msr_index)) begin
               r.general_protection = 1'b1;
            end
         end
         OPC_WRMSR: begin
            if (it.msr_index == MSR_NUM_TSC) begin
               tsc_off = it.write_data - it.host_time;
            end else if (it.msr_index >= MSR_NUM_SYS_CS && it.msr_index <= MSR_NUM_SYS_EIP) begin
               sysenter_q[sys_off[1:0]] = it.write_data;
            end else begin
               r.general_protection = 1'b1;
            end
         end
         default: begin
            r.handled = 1'b0;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                  rsp_count, what, got, want);
      end
      error_count++;
   endtask

   task automatic queue_item(input logic [2:0] op, input logic [31:0] leaf,
                             input logic [1:0] sub, input logic [31:0] keep,
                             input logic [31:0] setb, input logic [31:0] msr,
                             input logic [63:0] wdata, input logic [63:0] now);
      cpu_req_type it;
      it = '{op, leaf, sub, keep, setb, msr, wdata, now};
      pending_req.push_back(it);
   endtask

   function automatic logic [31:0] pick_leaf();
      int k;
      k = $urandom_range(0, 9);
      if (k <= 5) begin
         return LEAF_PICKS[$urandom_range(0, 13)];
      end else if (k == 6) begin
         return $urandom_range(0, 15);
      end else if (k == 7) begin
         return EXT_FLAG | $urandom_range(0, 15);
      end
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_msr();
      if ($urandom_range(0, 4) != 0) begin
         return MSR_PICKS[$urandom_range(0, 15)];
      end
      return $urandom;
   endfunction

   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Random requests; a table or MSR write is followed half of the time by a read of it.
   task automatic gen_random();
      cpu_req_type it;
      int          pick;
      while (pending_req.size() < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         it.leaf         = pick_leaf();
         it.sub_register = 2'($urandom);
         it.keep_mask    = $urandom;
         it.set_bits     = $urandom;
         it.msr_index    = pick_msr();
         it.write_data   = pick_wide();
         it.host_time    = pick_wide();
         if (pick < 30) begin
            it.operation = OPC_CPUID;
         end else if (pick < 45) begin
            it.operation = OPC_TBL_WR;
            case ($urandom_range(0, 3))
               0: begin
                  // Pull the word back to a small leaf count so lookups stay in range.
                  it.keep_mask = '0;
                  it.set_bits  = it.leaf[31] ? (EXT_FLAG | $urandom_range(0, 5))
                                             : 32'($urandom_range(0, 4));
               end
               1: begin
                  it.keep_mask = '1;
                  it.set_bits  = '0;
               end
               default: ;
            endcase
         end else if (pick < 55) begin
            it.operation = OPC_RDTSC;
         end else if (pick < 75) begin
            it.operation = OPC_RDMSR;
         end else if (pick < 95) begin
            it.operation = OPC_WRMSR;
         end else begin
            it.operation = 3'($urandom_range(OPC_LAST_UNUSED, OPC_FIRST_UNUSED));
         end
         pending_req.push_back(it);
         // Follow a write with a read of the same word half of the time.
         if ($urandom_range(0, 1) == 1) begin
            it.host_time = pick_wide();
            if (it.operation == OPC_WRMSR) begin
               it.operation = OPC_RDMSR;
               pending_req.push_back(it);
            end else if (it.operation == OPC_TBL_WR) begin
               it.operation = OPC_CPUID;
               pending_req.push_back(it);
            end
         end
      end
   endtask

   // Sender: offers pending beats, holding each until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
         req_push <= 1'b1;
      end else if (send_gap > 0) begin
         req_push <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_req.size() == 0) begin
         req_push <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         send_gap <= $urandom_range(0, 16);
      end else begin
         cur_req  <= pending_req.pop_front();
         req_push <= 1'b1;
      end
   end

   // Receiver: pops results, with random stall bursts and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!pressure_done && req_count >= PRESSURE_AT) begin
         rsp_pop       <= 1'b0;
         hold_left     <= PRESSURE_CYCLES - 1;
         pressure_done <= 1'b1;
      end else if (quiet_phase) begin
         rsp_pop <= 1'b1;
      end else if (pop_gap > 0) begin
         rsp_pop <= 1'b0;
         pop_gap <= pop_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         pop_gap <= $urandom_range(0, 16);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Predict on each accepted request and check each popped result beat.
   always @(posedge clock) begin
      req_taken <= req_push && !req_full;
      if (!reset) begin
         quiet_phase <= (req_count >= total_items - QUIET_ITEMS);
         if (req_push && !req_full) begin
            expected_rsp.push_back(emulate_op(cur_req));
            req_count++;
         end
         if (rsp_pop && !rsp_empty) begin
            got_rsp = {rsp_word_a, rsp_word_b, rsp_word_c, rsp_word_d, rsp_read_data,
                       rsp_general_protection, rsp_handled};
            if (expected_rsp.size() == 0) begin
               report_mismatch("beat with nothing expected, read_data",
                               got_rsp.read_data, 64'd0);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (got_rsp.word_a !== want_rsp.word_a)
                  report_mismatch("word_a", 64'(got_rsp.word_a), 64'(want_rsp.word_a));
               if (got_rsp.word_b !== want_rsp.word_b)
                  report_mismatch("word_b", 64'(got_rsp.word_b), 64'(want_rsp.word_b));
               if (got_rsp.word_c !== want_rsp.word_c)
                  report_mismatch("word_c", 64'(got_rsp.word_c), 64'(want_rsp.word_c));
               if (got_rsp.word_d !== want_rsp.word_d)
                  report_mismatch("word_d", 64'(got_rsp.word_d), 64'(want_rsp.word_d));
               if (got_rsp.read_data !== want_rsp.read_data)
                  report_mismatch("read_data", got_rsp.read_data, want_rsp.read_data);
               if (got_rsp.general_protection !== want_rsp.general_protection)
                  report_mismatch("general_protection", 64'(got_rsp.general_protection),
                                  64'(want_rsp.general_protection));
               if (got_rsp.handled !== want_rsp.handled)
                  report_mismatch("handled", 64'(got_rsp.handled), 64'(want_rsp.handled));
            end
            rsp_count++;
         end
      end
   end

   // Watchdog: ends the run when neither side moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      for (int i = 0; i < CPUID_SLOTS; i++) begin
         table_words[i] = CPUID_INIT[i];
      end
      tsc_off = '0;
      for (int i = 0; i < 3; i++) begin
         sysenter_q[i] = '0;
      end

      // Lookups at and around the stored leaf limits, and absent words.
      queue_item(OPC_CPUID, 32'h0, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h1, 2'd3, '1, '1, '1, '1, '1);
      queue_item(OPC_CPUID, 32'h3, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0000, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0001, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0004, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0005, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_CPUID, 32'hffff_ffff, 2'd0, '0, '0, '0, '0, '0);
      // Table writes: a present word, an absent entry, and a basic leaf whose
      // shifted address lands on an extended word.
      queue_item(OPC_TBL_WR, 32'h1, 2'd3, 32'hffff_0000, 32'h0000_1234, '0, '0, '0);
      queue_item(OPC_TBL_WR, 32'h5, 2'd0, '0, '1, '0, '0, '0);
      queue_item(OPC_TBL_WR, 32'h0800_0002, 2'd1, '0, 32'hdead_beef, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0002, 2'd0, '0, '0, '0, '0, '0);
      // Maximum basic leaf raised to all ones, then the address truncation.
      queue_item(OPC_TBL_WR, 32'h0, 2'd0, '0, '1, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h1000_0001, 2'd0, '0, '0, '0, '0, '0);
      queue_item(OPC_TBL_WR, 32'h0, 2'd0, '0, 32'h2, '0, '0, '0);
      // Maximum extended leaf lowered, so a former extended leaf falls back.
      queue_item(OPC_TBL_WR, 32'h8000_0000, 2'd0, '0, 32'h8000_0002, '0, '0, '0);
      queue_item(OPC_CPUID, 32'h8000_0004, 2'd0, '0, '0, '0, '0, '0);
      // Time stamp arithmetic that wraps.
      queue_item(OPC_RDTSC, '0, 2'd0, '0, '0, '0, '0, '1);
      queue_item(OPC_WRMSR, '0, 2'd0, '0, '0, MSR_NUM_TSC, '0, 64'd1);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, MSR_NUM_TSC, '0, '0);
      // SYSENTER registers, reserved MSRs and faulting MSRs.
      queue_item(OPC_WRMSR, '0, 2'd0, '0, '0, MSR_NUM_SYS_EIP, '1, '0);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, MSR_NUM_SYS_EIP, '0, '0);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, MSR_NUM_SYS_CS, '0, '0);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, MSR_NUM_FIX4_HI, '0, '0);
      queue_item(OPC_WRMSR, '0, 2'd0, '0, '0, MSR_NUM_UCODE, '1, '0);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, MSR_NUM_SYS_EIP + 32'd1, '0, '0);
      queue_item(OPC_RDMSR, '0, 2'd0, '0, '0, '1, '0, '0);
      // Operation codes the unit does not serve.
      queue_item(OPC_FIRST_UNUSED, '1, 2'd3, '1, '1, '1, '1, '1);
      queue_item(OPC_LAST_UNUSED, '0, 2'd0, '0, '0, '0, '0, '0);

      gen_random();
      total_items = pending_req.size();

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_push || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += expected_rsp.size();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
